/* rtl/lcs_pkg.sv */
// Shared types and constants for the LCS block with traceback.
// No dependencies; the top level and the cell import this package.
`timescale 1ns / 1ps
package lcs_pkg;
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [1:0] DIR_DIAG = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROW   = 6'b000010,
    ST_FLUSH = 6'b000100,
    ST_TRACE = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_WAIT  = 6'b100000
  } state_t;

  // Systolic token moving from one cell to the next.
  typedef struct packed {
    logic       vld;
    logic [7:0] sym;
    logic [6:0] left;
    logic [6:0] diag;
  } tok_t;
endpackage

/* rtl/lcs_with_traceback_top.sv */
// Top level of the LCS block: load logic, cell chain, direction RAM, traceback and output stage.
// Depends on lcs_pkg, lcs_cell and lcs_ram. Loads are accepted back to back while the block is idle.
// A start runs the rows, flushes the cell chain, walks the traceback one step at a time
// (at most n + m - 1 steps), primes the output, emits the results and passes through a wait state;
// a start with an empty string goes straight to the output stage.
// Reset is synchronous and clears both lengths and the overflow flag.
`timescale 1ns / 1ps
module lcs_with_traceback_top #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic [6:0] lcs_length,
  output logic       last,
  output logic       empty_res,
  output logic       overflow
);
  import lcs_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  state_t state;
  logic [6:0] len_a, len_b;
  logic ovf;
  logic acc;
  assign acc = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // First string store.
  logic [7:0] a_rd;
  logic [AW-1:0] a_raddr;
  lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(AW)) u_amem (
    .clk(clk), .we(acc && cmd == CMD_LOAD_A && len_a < 7'(MAX_LEN)),
    .waddr(len_a[AW-1:0]), .wdata(symbol), .raddr(a_raddr), .rdata(a_rd)
  );

  // Lengths and sticky overflow.
  logic run_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= '0; len_b <= '0; ovf <= 1'b0;
    end else if (run_done) begin
      len_a <= '0; len_b <= '0;
    end else if (acc && cmd == CMD_LOAD_A) begin
      if (len_a < 7'(MAX_LEN)) len_a <= len_a + 7'd1;
      else ovf <= 1'b1;
    end else if (acc && cmd == CMD_LOAD_B) begin
      if (len_b < 7'(MAX_LEN)) len_b <= len_b + 7'd1;
      else ovf <= 1'b1;
    end
  end

  // Cell chain.
  tok_t tk [MAX_LEN+1];
  logic [1:0] dirs [MAX_LEN];
  logic clr;
  logic [AW:0] row_cnt; // rows issued
  for (genvar c = 0; c < MAX_LEN; c++) begin : g_cell
    lcs_cell u_cell (
      .clk(clk), .rst(rst),
      .load(acc && cmd == CMD_LOAD_B && len_b == 7'(c)),
      .load_sym(symbol), .clear(clr),
      .tin(tk[c]), .tout(tk[c+1]), .dir(dirs[c])
    );
  end

  // Row index travelling with each token, to address the direction RAM.
  logic [AW-1:0] row_tag [MAX_LEN];
  logic row_inj;
  assign row_inj = (state == ST_ROW) && (row_cnt != '0);
  always_ff @(posedge clk) begin
    row_tag[0] <= AW'(row_cnt - 1'b1);
    for (int c = 1; c < MAX_LEN; c++) row_tag[c] <= row_tag[c-1];
  end

  // Row injection: symbol a[i], read from the registered string store, enters cell 0.
  logic tk0_vld;
  always_ff @(posedge clk) begin
    if (rst) tk0_vld <= 1'b0;
    else tk0_vld <= row_inj;
  end
  // The valid bit is registered so it lines up with the registered string read.
  assign tk[0] = '{vld: tk0_vld, sym: a_rd, left: 7'd0, diag: 7'd0};

  // Direction RAM writes: each column writes its own RAM as its token passes.
  logic [1:0] dir_rd [MAX_LEN];
  logic [AW-1:0] t_i, t_j;
  for (genvar c = 0; c < MAX_LEN; c++) begin : g_dram
    lcs_ram #(.WIDTH(2), .DEPTH(MAX_LEN), .AW(AW)) u_dram (
      .clk(clk), .we(tk[c].vld && 7'(c) < len_b), .waddr(row_tag[c]),
      .wdata(dirs[c]), .raddr(t_i), .rdata(dir_rd[c])
    );
  end

  // Sequencer.
  logic [7:0] flush_cnt;
  logic [6:0] cnt;
  logic [6:0] emit_k;
  logic rd_phase;
  logic trace_end;
  logic [1:0] cur_dir;
  logic out_acc;
  logic out_primed;
  logic [7:0] rev_rd;
  logic [AW-1:0] rev_raddr;
  assign cur_dir = dir_rd[t_j];
  assign a_raddr = (state == ST_TRACE) ? t_i : AW'(row_cnt - 1'b1);
  assign clr = (state == ST_IDLE);
  assign out_acc = out_valid && !out_stall;
  assign run_done = (state == ST_EMIT) && out_acc && last;

  // End of the traceback walk after the current step.
  always_comb begin
    if (cur_dir == DIR_DIAG) trace_end = (t_i == '0) || (t_j == '0);
    else if (cur_dir == DIR_UP) trace_end = (t_i == '0);
    else trace_end = (t_j == '0);
  end

  // Traced symbols in reverse order; read ahead of each output request.
  assign rev_raddr = AW'(cnt - 7'd1 - emit_k - {6'd0, out_acc});
  lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN), .AW(AW)) u_rev (
    .clk(clk),
    .we((state == ST_TRACE) && rd_phase && cur_dir == DIR_DIAG),
    .waddr(cnt[AW-1:0]), .wdata(a_rd), .raddr(rev_raddr), .rdata(rev_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          row_cnt <= '0;
          if (acc && cmd == CMD_START) begin
            state <= (len_a == 7'd0 || len_b == 7'd0) ? ST_EMIT : ST_ROW;
            cnt <= 7'd0; emit_k <= 7'd0;
          end
        end
        ST_ROW: begin
          if (row_cnt == (AW+1)'(len_a)) begin
            state <= ST_FLUSH; flush_cnt <= 8'(MAX_LEN) + 8'd2;
          end else row_cnt <= row_cnt + 1'b1;
        end
        ST_FLUSH: begin
          flush_cnt <= flush_cnt - 8'd1;
          if (flush_cnt == 8'd0) begin
            state <= ST_TRACE; rd_phase <= 1'b0;
            t_i <= AW'(len_a - 7'd1); t_j <= AW'(len_b - 7'd1);
          end
        end
        ST_TRACE: begin
          rd_phase <= !rd_phase;
          if (rd_phase) begin
            if (cur_dir == DIR_DIAG) begin
              cnt <= cnt + 7'd1;
              t_i <= t_i - 1'b1; t_j <= t_j - 1'b1;
            end else if (cur_dir == DIR_UP) begin
              t_i <= t_i - 1'b1;
            end else begin
              t_j <= t_j - 1'b1;
            end
            if (trace_end) state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            emit_k <= emit_k + 7'd1;
            if (last) state <= ST_WAIT;
          end
        end
        ST_WAIT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The first output cycle only primes the reverse buffer read.
  always_ff @(posedge clk) begin
    if (rst) out_primed <= 1'b0;
    else out_primed <= (state == ST_EMIT);
  end

  // Output drive from the reverse buffer read port.
  assign out_valid = (state == ST_EMIT) && out_primed;
  assign empty_res = (cnt == 7'd0);
  assign lcs_length = cnt;
  assign last = empty_res || (emit_k + 7'd1 == cnt);
  assign out_symbol = empty_res ? 8'd0 : rev_rd;
  assign overflow = ovf;

`ifndef SYNTHESIS
  // No request is taken while a run is in flight.
  a_no_acc: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !acc) else $error("request taken during run");
  // The lengths clear after the final result of a run.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    run_done |=> (len_a == 7'd0 && len_b == 7'd0)) else $error("lengths not cleared");
  // Overflow never falls outside reset.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    !$fell(ovf)) else $error("overflow cleared");
`endif
endmodule

/* rtl/lcs_ram.sv */
// Generic single-port write, single-port registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/lcs_cell.sv */
// One column cell of the LCS score row: holds one symbol of the second
// string and its running score. Depends on lcs_pkg.
`timescale 1ns / 1ps
module lcs_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [7:0]    load_sym,
  input  logic          clear,
  input  lcs_pkg::tok_t tin,
  output lcs_pkg::tok_t tout,
  output logic [1:0]    dir
);
  import lcs_pkg::*;

  logic [7:0] col_sym;
  logic [6:0] score;
  logic [6:0] val;

  // Score update for one table cell.
  always_comb begin
    if (tin.sym == col_sym) begin
      val = tin.diag + 7'd1;
      dir = DIR_DIAG;
    end else if (score >= tin.left) begin
      val = score;
      dir = DIR_UP;
    end else begin
      val = tin.left;
      dir = DIR_LEFT;
    end
  end

  // Column symbol and score registers.
  always_ff @(posedge clk) begin
    if (load) col_sym <= load_sym;
    if (clear) score <= 7'd0;
    else if (tin.vld) score <= val;
  end

  // Token handed to the right-hand neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      tout.vld <= 1'b0;
    end else begin
      tout.vld <= tin.vld;
    end
    tout.sym  <= tin.sym;
    tout.left <= val;
    tout.diag <= score;
  end
endmodule
